>>> hw/rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion macros shared by the RTL. Define ASSERT_OFF to drop
// every check from the build.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Clocked check, masked while reset is asserted (active low).
`define ASSERT_CHK(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) prop) else $error(msg);

// Clocked check that also holds during reset.
`define ASSERT_CHK_NR(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define ASSERT_CHK(lbl, clk, rstn, prop, msg)
`define ASSERT_CHK_NR(lbl, clk, prop, msg)

`endif

`endif

>>> hw/rtl/stt_pkg.sv
// ---------------------------------------------------------------------------
// stt_pkg
// Types, character codes, token kinds and lookup functions for the
// source text tokenizer.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package stt_pkg;

  localparam int LINE_BITS_DEF   = 16;
  localparam int COLUMN_BITS_DEF = 16;

  localparam int CHAR_W  = 8;
  localparam int KIND_W  = 5;
  localparam int FIELD_W = 16;
  localparam int PREFIX_W = 40;

  localparam logic [FIELD_W-1:0] LEN_MAX = 16'hFFFF;

  // Output queue depth; one beat may push two results.
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  // Character codes
  localparam logic [7:0] CH_NL      = 8'h0A;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_BANG    = 8'h21;
  localparam logic [7:0] CH_DQUOTE  = 8'h22;
  localparam logic [7:0] CH_HASH    = 8'h23;
  localparam logic [7:0] CH_PERCENT = 8'h25;
  localparam logic [7:0] CH_AMP     = 8'h26;
  localparam logic [7:0] CH_SQUOTE  = 8'h27;
  localparam logic [7:0] CH_LPAREN  = 8'h28;
  localparam logic [7:0] CH_RPAREN  = 8'h29;
  localparam logic [7:0] CH_STAR    = 8'h2A;
  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_MINUS   = 8'h2D;
  localparam logic [7:0] CH_SLASH   = 8'h2F;
  localparam logic [7:0] CH_SEMI    = 8'h3B;
  localparam logic [7:0] CH_LT      = 8'h3C;
  localparam logic [7:0] CH_EQ      = 8'h3D;
  localparam logic [7:0] CH_GT      = 8'h3E;
  localparam logic [7:0] CH_LBRACE  = 8'h7B;
  localparam logic [7:0] CH_PIPE    = 8'h7C;
  localparam logic [7:0] CH_RBRACE  = 8'h7D;

  // Keyword prefixes, first byte highest
  localparam logic [PREFIX_W-1:0] KW_IF    = 40'h00_0000_6966;
  localparam logic [PREFIX_W-1:0] KW_ELSE  = 40'h00_656C_7365;
  localparam logic [PREFIX_W-1:0] KW_WHILE = 40'h77_6869_6C65;
  localparam logic [PREFIX_W-1:0] KW_FOR   = 40'h00_0066_6F72;
  localparam logic [PREFIX_W-1:0] KW_TRUE  = 40'h00_7472_7565;
  localparam logic [PREFIX_W-1:0] KW_FALSE = 40'h66_616C_7365;
  localparam logic [PREFIX_W-1:0] KW_VAR   = 40'h00_0076_6172;
  localparam logic [PREFIX_W-1:0] KW_PRINT = 40'h70_7269_6E74;
  localparam logic [FIELD_W-1:0]  KW_MAX_LEN = 16'd5;

  typedef enum logic [KIND_W-1:0] {
    K_UNKNOWN = 5'd0,  K_SEMI    = 5'd1,  K_NUMBER  = 5'd2,  K_PLUS    = 5'd3,
    K_MINUS   = 5'd4,  K_STAR    = 5'd5,  K_SLASH   = 5'd6,  K_LPAREN  = 5'd7,
    K_RPAREN  = 5'd8,  K_ASSIGN  = 5'd9,  K_PERCENT = 5'd10, K_STRING  = 5'd11,
    K_CHAR    = 5'd12, K_COMMENT = 5'd13, K_LT      = 5'd14, K_GT      = 5'd15,
    K_NE      = 5'd16, K_LE      = 5'd17, K_GE      = 5'd18, K_AND     = 5'd19,
    K_OR      = 5'd20, K_EQ      = 5'd21, K_LBRACE  = 5'd22, K_RBRACE  = 5'd23,
    K_IF      = 5'd24, K_ELSE    = 5'd25, K_WHILE   = 5'd26, K_FOR     = 5'd27,
    K_BOOL    = 5'd28, K_VAR     = 5'd29, K_PRINT   = 5'd30, K_IDENT   = 5'd31
  } kind_t;

  typedef enum logic [8:0] {
    MODE_START = 9'b000000001,
    MODE_IDLE  = 9'b000000010,
    MODE_NUM   = 9'b000000100,
    MODE_IDENT = 9'b000001000,
    MODE_STR   = 9'b000010000,
    MODE_CHR   = 9'b000100000,
    MODE_COMM  = 9'b001000000,
    MODE_SKIP  = 9'b010000000,
    MODE_OP    = 9'b100000000
  } mode_t;

  // What closing the open token would report
  typedef struct packed {
    logic               valid;
    kind_t              kind;
    logic [FIELD_W-1:0] len;
  } flush_t;

  typedef struct packed {
    kind_t              kind;
    logic [FIELD_W-1:0] start;
    logic [FIELD_W-1:0] len;
  } res_t;

  typedef struct packed {
    logic [KIND_W-1:0]  token_kind;
    logic [FIELD_W-1:0] line_number;
    logic [FIELD_W-1:0] start_column;
    logic [FIELD_W-1:0] symbol_length;
    logic               last_of_run;
  } out_beat_t;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
  endfunction

  function automatic kind_t ident_kind(input logic [FIELD_W-1:0] len,
                                       input logic [PREFIX_W-1:0] prefix);
    kind_t k;
    k = K_IDENT;
    if (len <= KW_MAX_LEN) begin
      case (prefix)
        KW_IF:    k = K_IF;
        KW_ELSE:  k = K_ELSE;
        KW_WHILE: k = K_WHILE;
        KW_FOR:   k = K_FOR;
        KW_TRUE:  k = K_BOOL;
        KW_FALSE: k = K_BOOL;
        KW_VAR:   k = K_VAR;
        KW_PRINT: k = K_PRINT;
        default:  k = K_IDENT;
      endcase
    end
    return k;
  endfunction

  function automatic kind_t single_op_kind(input logic [7:0] a);
    kind_t k;
    case (a)
      CH_LT:   k = K_LT;
      CH_GT:   k = K_GT;
      CH_EQ:   k = K_ASSIGN;
      default: k = K_UNKNOWN;
    endcase
    return k;
  endfunction

  function automatic kind_t pair_kind(input logic [7:0] a, input logic [7:0] b);
    kind_t k;
    k = K_UNKNOWN;
    if (b == CH_EQ) begin
      case (a)
        CH_LT:   k = K_LE;
        CH_GT:   k = K_GE;
        CH_BANG: k = K_NE;
        CH_EQ:   k = K_EQ;
        default: k = K_UNKNOWN;
      endcase
    end
    if ((a == CH_AMP) && (b == CH_AMP))   k = K_AND;
    if ((a == CH_PIPE) && (b == CH_PIPE)) k = K_OR;
    return k;
  endfunction

  function automatic flush_t flush_info(input mode_t mode,
                                        input logic [FIELD_W-1:0] len,
                                        input logic [PREFIX_W-1:0] prefix,
                                        input logic [7:0] pend);
    flush_t f;
    f.valid = 1'b1;
    f.kind  = K_UNKNOWN;
    f.len   = len;
    case (mode)
      MODE_NUM:   f.kind = K_NUMBER;
      MODE_IDENT: f.kind = ident_kind(len, prefix);
      MODE_STR:   f.kind = K_STRING;
      MODE_CHR:   f.kind = K_CHAR;
      MODE_COMM:  f.kind = K_COMMENT;
      MODE_OP: begin
        f.kind = single_op_kind(pend);
        f.len  = (f.kind == K_UNKNOWN) ? '0 : FIELD_W'(1);
      end
      default: begin
        f.valid = 1'b0;
        f.len   = '0;
      end
    endcase
    return f;
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/stt_in_if.sv
// ---------------------------------------------------------------------------
// stt_in_if
// Byte channel into the tokenizer: valid/ready with one source byte a beat.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface stt_in_if;
  logic                        valid;
  logic                        ready;
  logic [stt_pkg::CHAR_W-1:0]  char_code;
  logic                        end_of_input;

  modport source (output valid, output char_code, output end_of_input, input ready);
  modport sink   (input valid, input char_code, input end_of_input, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/stt_out_if.sv
// ---------------------------------------------------------------------------
// stt_out_if
// Token channel out of the tokenizer: valid/ready with one token a beat.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface stt_out_if;
  logic                         valid;
  logic                         ready;
  logic [stt_pkg::KIND_W-1:0]   token_kind;
  logic [stt_pkg::FIELD_W-1:0]  line_number;
  logic [stt_pkg::FIELD_W-1:0]  start_column;
  logic [stt_pkg::FIELD_W-1:0]  symbol_length;
  logic                         last_of_run;

  modport source (output valid, output token_kind, output line_number, output start_column,
                  output symbol_length, output last_of_run, input ready);
  modport sink   (input valid, input token_kind, input line_number, input start_column,
                  input symbol_length, input last_of_run, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/source_text_tokenizer.sv
// ---------------------------------------------------------------------------
// source_text_tokenizer
// Streaming lexer: source bytes in, tokens (kind, line, column, length) out.
// ---------------------------------------------------------------------------
// Usage:
//   in_ch  takes one source byte a beat; end_of_input marks the last byte of
//          a text. After that byte any open token is closed and the line and
//          column counters start over.
//   out_ch gives one token a beat. One byte yields zero, one or two tokens;
//          last_of_run is set on the final token that a byte produced.
// Output: tokens land in a four-entry output queue, and out_ch shows its head.
// Throughput: one byte per cycle while in_ch is ready. The mode, counters
//   and token bookkeeping update from the byte. in_ch.ready is low while
//   fewer than two queue entries are free, so bytes that yield two tokens
//   each run at most at the drain rate.
// Stall: when out_ch.ready is low the queue fills, then in_ch.ready drops;
//   no token is lost or repeated.
// Reset (rst_n low, synchronous): queue emptied, line back to one, column
//   and token state cleared, lexer at the start of a line.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module source_text_tokenizer #(
  parameter int LINE_BITS   = stt_pkg::LINE_BITS_DEF,
  parameter int COLUMN_BITS = stt_pkg::COLUMN_BITS_DEF
) (
  input  wire           clk,
  input  wire           rst_n,
  stt_in_if.sink        in_ch,
  stt_out_if.source     out_ch
);

  localparam int FW = stt_pkg::FIELD_W;
  localparam int PW = stt_pkg::FIFO_PTR_W;
  localparam int CW = stt_pkg::FIFO_CNT_W;

  // Lexer state
  stt_pkg::mode_t                  mode_r, mode_stp, mode_nxt;
  logic [LINE_BITS-1:0]            line_r, line_stp, line_nxt;
  logic [COLUMN_BITS-1:0]          col_r, col_stp, col_nxt;
  logic [COLUMN_BITS-1:0]          start_r, start_stp, start_nxt;
  logic [FW-1:0]                   len_r, len_stp, len_nxt;
  logic [stt_pkg::PREFIX_W-1:0]    prefix_r, prefix_stp, prefix_nxt;
  logic [7:0]                      pend_r, pend_stp, pend_nxt;

  // Output queue
  stt_pkg::out_beat_t              fifo_r [stt_pkg::FIFO_DEPTH];
  logic [PW-1:0]                   wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]                   count_r;

  logic                            in_fire, pop;
  logic [7:0]                      ch;
  logic                            a_v, b_v, c_v, do_begin;
  stt_pkg::res_t                   a_res, b_res, c_res, r0, r1;
  stt_pkg::flush_t                 fl_cur, fl_stp;
  stt_pkg::kind_t                  pk;
  logic [1:0]                      res_n, push_n;
  logic [FW-1:0]                   line_out;
  stt_pkg::out_beat_t              beat0, beat1, head;

  function automatic logic [FW-1:0] clamp_line(input logic [LINE_BITS-1:0] v);
    logic [31:0] w;
    w = 32'(v);
    return (w > 32'h0000_FFFF) ? 16'hFFFF : w[FW-1:0];
  endfunction

  function automatic logic [FW-1:0] clamp_col(input logic [COLUMN_BITS-1:0] v);
    logic [31:0] w;
    w = 32'(v);
    return (w > 32'h0000_FFFF) ? 16'hFFFF : w[FW-1:0];
  endfunction

  function automatic logic [FW-1:0] grow(input logic [FW-1:0] v);
    return (v == stt_pkg::LEN_MAX) ? v : v + FW'(1);
  endfunction

  assign in_fire     = in_ch.valid && in_ch.ready;
  assign pop         = out_ch.valid && out_ch.ready;
  assign in_ch.ready = (count_r < CW'(stt_pkg::FIFO_DEPTH - 1));
  assign ch          = in_ch.char_code;

  // One byte: step the open token, start a new one if needed, then flush
  // on end of input.
  always_comb begin
    mode_stp   = mode_r;
    line_stp   = line_r;
    col_stp    = col_r;
    start_stp  = start_r;
    len_stp    = len_r;
    prefix_stp = prefix_r;
    pend_stp   = pend_r;
    a_v        = 1'b0;
    b_v        = 1'b0;
    do_begin   = 1'b0;
    fl_cur     = stt_pkg::flush_info(mode_r, len_r, prefix_r, pend_r);
    pk         = stt_pkg::pair_kind(pend_r, ch);
    a_res      = '{kind: fl_cur.kind, start: clamp_col(start_r), len: fl_cur.len};
    b_res      = '{kind: stt_pkg::K_UNKNOWN, start: clamp_col(col_r), len: '0};

    if (ch == stt_pkg::CH_NL) begin
      a_v      = fl_cur.valid;
      mode_stp = stt_pkg::MODE_START;
      col_stp  = '0;
      if (line_r != {LINE_BITS{1'b1}}) line_stp = line_r + LINE_BITS'(1);
    end else begin
      case (mode_r)
        stt_pkg::MODE_SKIP: ;
        stt_pkg::MODE_START: begin
          if (ch == stt_pkg::CH_HASH) mode_stp = stt_pkg::MODE_SKIP;
          else do_begin = 1'b1;
        end
        stt_pkg::MODE_NUM: begin
          if (stt_pkg::is_digit(ch)) begin
            len_stp = grow(len_r);
          end else begin
            a_v      = 1'b1;
            do_begin = 1'b1;
          end
        end
        stt_pkg::MODE_IDENT: begin
          if (stt_pkg::is_alpha(ch) || stt_pkg::is_digit(ch)) begin
            if (len_r < stt_pkg::KW_MAX_LEN) prefix_stp = {prefix_r[31:0], ch};
            len_stp = grow(len_r);
          end else begin
            a_v      = 1'b1;
            do_begin = 1'b1;
          end
        end
        stt_pkg::MODE_STR: begin
          if (ch == stt_pkg::CH_DQUOTE) begin
            a_v      = 1'b1;
            mode_stp = stt_pkg::MODE_IDLE;
          end else begin
            len_stp = grow(len_r);
          end
        end
        stt_pkg::MODE_CHR: begin
          if (ch == stt_pkg::CH_SQUOTE) begin
            a_v      = 1'b1;
            mode_stp = stt_pkg::MODE_IDLE;
          end else begin
            len_stp = grow(len_r);
          end
        end
        stt_pkg::MODE_COMM: len_stp = grow(len_r);
        stt_pkg::MODE_OP: begin
          a_v = 1'b1;
          if (pk != stt_pkg::K_UNKNOWN) begin
            a_res.kind = pk;
            a_res.len  = FW'(2);
            mode_stp   = stt_pkg::MODE_IDLE;
          end else begin
            do_begin = 1'b1;
          end
        end
        default: do_begin = 1'b1;
      endcase

      if (do_begin) begin
        mode_stp = stt_pkg::MODE_IDLE;
        b_res.len = FW'(1);
        case (ch)
          stt_pkg::CH_SPACE:   ;
          stt_pkg::CH_SEMI:    begin b_v = 1'b1; b_res.kind = stt_pkg::K_SEMI;    end
          stt_pkg::CH_PLUS:    begin b_v = 1'b1; b_res.kind = stt_pkg::K_PLUS;    end
          stt_pkg::CH_MINUS:   begin b_v = 1'b1; b_res.kind = stt_pkg::K_MINUS;   end
          stt_pkg::CH_STAR:    begin b_v = 1'b1; b_res.kind = stt_pkg::K_STAR;    end
          stt_pkg::CH_SLASH:   begin b_v = 1'b1; b_res.kind = stt_pkg::K_SLASH;   end
          stt_pkg::CH_LPAREN:  begin b_v = 1'b1; b_res.kind = stt_pkg::K_LPAREN;  end
          stt_pkg::CH_RPAREN:  begin b_v = 1'b1; b_res.kind = stt_pkg::K_RPAREN;  end
          stt_pkg::CH_PERCENT: begin b_v = 1'b1; b_res.kind = stt_pkg::K_PERCENT; end
          stt_pkg::CH_LBRACE:  begin b_v = 1'b1; b_res.kind = stt_pkg::K_LBRACE;  end
          stt_pkg::CH_RBRACE:  begin b_v = 1'b1; b_res.kind = stt_pkg::K_RBRACE;  end
          stt_pkg::CH_DQUOTE: begin
            mode_stp  = stt_pkg::MODE_STR;
            start_stp = col_r;
            len_stp   = '0;
          end
          stt_pkg::CH_SQUOTE: begin
            mode_stp  = stt_pkg::MODE_CHR;
            start_stp = col_r;
            len_stp   = '0;
          end
          stt_pkg::CH_HASH: begin
            mode_stp  = stt_pkg::MODE_COMM;
            start_stp = col_r;
            len_stp   = FW'(1);
          end
          stt_pkg::CH_LT, stt_pkg::CH_GT, stt_pkg::CH_BANG,
          stt_pkg::CH_AMP, stt_pkg::CH_PIPE, stt_pkg::CH_EQ: begin
            mode_stp  = stt_pkg::MODE_OP;
            start_stp = col_r;
            len_stp   = FW'(1);
            pend_stp  = ch;
          end
          default: begin
            if (stt_pkg::is_digit(ch)) begin
              mode_stp  = stt_pkg::MODE_NUM;
              start_stp = col_r;
              len_stp   = FW'(1);
            end else if (stt_pkg::is_alpha(ch)) begin
              mode_stp   = stt_pkg::MODE_IDENT;
              start_stp  = col_r;
              len_stp    = FW'(1);
              prefix_stp = {32'h0, ch};
            end else begin
              b_v       = 1'b1;
              b_res.len = '0;
            end
          end
        endcase
      end

      if (col_r != {COLUMN_BITS{1'b1}}) col_stp = col_r + COLUMN_BITS'(1);
    end

    // End of input closes whatever the byte left open
    fl_stp = stt_pkg::flush_info(mode_stp, len_stp, prefix_stp, pend_stp);
    c_v    = in_ch.end_of_input && fl_stp.valid;
    c_res  = '{kind: fl_stp.kind, start: clamp_col(start_stp), len: fl_stp.len};

    if (in_ch.end_of_input) begin
      mode_nxt   = stt_pkg::MODE_START;
      line_nxt   = LINE_BITS'(1);
      col_nxt    = '0;
      start_nxt  = '0;
      len_nxt    = '0;
      prefix_nxt = '0;
      pend_nxt   = '0;
    end else begin
      mode_nxt   = mode_stp;
      line_nxt   = line_stp;
      col_nxt    = col_stp;
      start_nxt  = start_stp;
      len_nxt    = len_stp;
      prefix_nxt = prefix_stp;
      pend_nxt   = pend_stp;
    end
  end

  // Pack up to two results in order
  always_comb begin
    res_n    = {1'b0, a_v} + {1'b0, b_v} + {1'b0, c_v};
    push_n   = in_fire ? res_n : 2'd0;
    r0       = a_v ? a_res : (b_v ? b_res : c_res);
    r1       = (a_v && b_v) ? b_res : c_res;
    line_out = clamp_line(line_r);
    beat0    = '{token_kind: r0.kind, line_number: line_out, start_column: r0.start,
                 symbol_length: r0.len, last_of_run: (res_n == 2'd1)};
    beat1    = '{token_kind: r1.kind, line_number: line_out, start_column: r1.start,
                 symbol_length: r1.len, last_of_run: 1'b1};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= stt_pkg::MODE_START;
      line_r   <= LINE_BITS'(1);
      col_r    <= '0;
      start_r  <= '0;
      len_r    <= '0;
      prefix_r <= '0;
      pend_r   <= '0;
    end else if (in_fire) begin
      mode_r   <= mode_nxt;
      line_r   <= line_nxt;
      col_r    <= col_nxt;
      start_r  <= start_nxt;
      len_r    <= len_nxt;
      prefix_r <= prefix_nxt;
      pend_r   <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_r + PW'(push_n);
      if (pop) rd_ptr_r <= rd_ptr_r + PW'(1);
      count_r  <= count_r + CW'(push_n) - CW'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push_n != 2'd0) fifo_r[wr_ptr_r] <= beat0;
    if (push_n == 2'd2) fifo_r[wr_ptr_r + PW'(1)] <= beat1;
  end

  assign head                 = fifo_r[rd_ptr_r];
  assign out_ch.valid         = (count_r != '0);
  assign out_ch.token_kind    = head.token_kind;
  assign out_ch.line_number   = head.line_number;
  assign out_ch.start_column  = head.start_column;
  assign out_ch.symbol_length = head.symbol_length;
  assign out_ch.last_of_run   = head.last_of_run;

  // Checks
  `ASSERT_CHK(a_eoi_restart, clk, rst_n, (in_fire && in_ch.end_of_input) |=> (line_r == LINE_BITS'(1) && col_r == '0 && mode_r == stt_pkg::MODE_START), "counters not restarted after end of input")
  `ASSERT_CHK(a_push_visible, clk, rst_n, (push_n != 2'd0) |=> out_ch.valid, "pushed token not presented")
  `ASSERT_CHK(a_no_overflow, clk, rst_n, count_r <= CW'(stt_pkg::FIFO_DEPTH), "output queue overflow")

endmodule

`default_nettype wire

>>> verif/source_text_tokenizer_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// source_text_tokenizer_tb
// Self-checking bench for the streaming lexer. A short fixed source text
// opens the run, with a few tokens written out by hand. After it comes
// random source text built from keywords, names, numbers, literals,
// comments, operators and noise bytes, and a last stretch runs without
// gaps. Each accepted byte goes through a local lexer model. Every
// token beat is checked field by field against the oldest token waiting.
// ---------------------------------------------------------------------------

module source_text_tokenizer_tb;
  import stt_pkg::*;

  typedef struct packed {
    logic [7:0] ch;
    logic       eoi;
    logic       fixed;   // token below is written by hand, not modeled
    logic [1:0] n_res;
    out_beat_t  res;
  } text_row_t;

  localparam int PROBE_LEN = 23;
  localparam text_row_t PROBE_TEXT [PROBE_LEN] = '{
    // hash at line start: whole line dropped, still counted
    '{CH_HASH,   1'b0, 1'b1, 2'd0, '0},
    '{8'h78,     1'b0, 1'b1, 2'd0, '0},
    '{CH_NL,     1'b0, 1'b1, 2'd0, '0},
    '{CH_NL,     1'b0, 1'b1, 2'd0, '0},
    '{8'h00,     1'b0, 1'b1, 2'd1, '{K_UNKNOWN, 16'd3, 16'd0, 16'd0, 1'b1}},
    '{8'hFF,     1'b0, 1'b1, 2'd1, '{K_UNKNOWN, 16'd3, 16'd1, 16'd0, 1'b1}},
    '{CH_LT,     1'b0, 1'b1, 2'd0, '0},
    '{CH_EQ,     1'b0, 1'b1, 2'd1, '{K_LE, 16'd3, 16'd2, 16'd2, 1'b1}},
    // lone '!' then "while"
    '{CH_BANG,   1'b0, 1'b0, 2'd0, '0},
    '{8'h77,     1'b0, 1'b0, 2'd0, '0},
    '{8'h68,     1'b0, 1'b0, 2'd0, '0},
    '{8'h69,     1'b0, 1'b0, 2'd0, '0},
    '{8'h6C,     1'b0, 1'b0, 2'd0, '0},
    '{8'h65,     1'b0, 1'b0, 2'd0, '0},
    // string left open at end of line
    '{CH_DQUOTE, 1'b0, 1'b0, 2'd0, '0},
    '{8'h71,     1'b0, 1'b0, 2'd0, '0},
    '{CH_NL,     1'b0, 1'b0, 2'd0, '0},
    '{8'h37,     1'b0, 1'b0, 2'd0, '0},
    '{CH_AMP,    1'b0, 1'b0, 2'd0, '0},
    '{CH_AMP,    1'b0, 1'b0, 2'd0, '0},
    // mid-line comment closed by end of input
    '{CH_HASH,   1'b0, 1'b0, 2'd0, '0},
    '{8'h7F,     1'b0, 1'b0, 2'd0, '0},
    '{CH_SQUOTE, 1'b1, 1'b0, 2'd0, '0}
  };

  logic clk;
  logic rst_n;

  stt_in_if  in_ch ();
  stt_out_if out_ch ();

  source_text_tokenizer DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // lexer model state
  mode_t       lex_mode;
  logic [15:0] line_cnt;
  logic [15:0] col_cnt;
  logic [15:0] tok_start;
  logic [15:0] tok_len;
  logic [39:0] word_prefix;
  logic [7:0]  op_first;
  out_beat_t   step_tok [2];
  int          step_n;

  out_beat_t   token_q [$];
  int          mismatches = 0;
  bit          src_gaps_on = 1'b0;
  bit          snk_gaps_on = 1'b0;
  int          snk_hold = 0;

  logic [7:0]  frag [$];
  bit          frag_ignored;

  string kw_words [12] = '{"if", "else", "while", "for", "true", "false", "var",
                           "print", "iff", "prin", "whiles", "Else"};
  string op_words [22] = '{"<=", ">=", "!=", "==", "&&", "||", "<", ">", "=", "!",
                           "&", "|", "+", "-", "*", "/", "(", ")", "%", ";", "{", "}"};

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #500_000;
    $display("Regression FAIL");
    $finish;
  end

  // ---------------------------------------------------------------- model
  function automatic bit is_num(input logic [7:0] c);
    return (c >= "0") && (c <= "9");
  endfunction

  function automatic bit is_letter(input logic [7:0] c);
    return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
  endfunction

  function automatic void lex_reset();
    lex_mode    = MODE_START;
    line_cnt    = 16'd1;
    col_cnt     = '0;
    tok_start   = '0;
    tok_len     = '0;
    word_prefix = '0;
    op_first    = '0;
  endfunction

  function automatic void add_tok(input kind_t k, input logic [15:0] st,
                                  input logic [15:0] ln);
    if (step_n < 2) begin
      step_tok[step_n] = '{k, line_cnt, st, ln, 1'b0};
      step_n++;
    end
  endfunction

  function automatic void grow_tok();
    if (tok_len != 16'hFFFF) tok_len++;
  endfunction

  // keywords only match when the whole word fits in the prefix
  function automatic kind_t word_kind();
    if (tok_len > 16'd5) return K_IDENT;
    case (word_prefix)
      KW_IF:              return K_IF;
      KW_ELSE:            return K_ELSE;
      KW_WHILE:           return K_WHILE;
      KW_FOR:             return K_FOR;
      KW_TRUE, KW_FALSE:  return K_BOOL;
      KW_VAR:             return K_VAR;
      KW_PRINT:           return K_PRINT;
      default:            return K_IDENT;
    endcase
  endfunction

  function automatic kind_t lone_op(input logic [7:0] c);
    case (c)
      CH_LT:   return K_LT;
      CH_GT:   return K_GT;
      CH_EQ:   return K_ASSIGN;
      default: return K_UNKNOWN;
    endcase
  endfunction

  function automatic kind_t op_pair(input logic [7:0] a, input logic [7:0] b);
    if ((a == CH_AMP) && (b == CH_AMP)) return K_AND;
    if ((a == CH_PIPE) && (b == CH_PIPE)) return K_OR;
    if (b != CH_EQ) return K_UNKNOWN;
    case (a)
      CH_LT:   return K_LE;
      CH_GT:   return K_GE;
      CH_BANG: return K_NE;
      CH_EQ:   return K_EQ;
      default: return K_UNKNOWN;
    endcase
  endfunction

  function automatic void close_open();
    kind_t k;
    case (lex_mode)
      MODE_NUM:   add_tok(K_NUMBER, tok_start, tok_len);
      MODE_IDENT: add_tok(word_kind(), tok_start, tok_len);
      MODE_STR:   add_tok(K_STRING, tok_start, tok_len);
      MODE_CHR:   add_tok(K_CHAR, tok_start, tok_len);
      MODE_COMM:  add_tok(K_COMMENT, tok_start, tok_len);
      MODE_OP: begin
        k = lone_op(op_first);
        add_tok(k, tok_start, (k == K_UNKNOWN) ? 16'd0 : 16'd1);
      end
      default: ;
    endcase
  endfunction

  function automatic void open_tok(input mode_t m, input logic [15:0] col,
                                   input logic [15:0] ln);
    lex_mode  = m;
    tok_start = col;
    tok_len   = ln;
  endfunction

  // byte that lands outside any open token
  function automatic void take_fresh(input logic [7:0] c, input logic [15:0] col);
    lex_mode = MODE_IDLE;
    case (c)
      CH_SPACE:   ;
      CH_SEMI:    add_tok(K_SEMI, col, 16'd1);
      CH_PLUS:    add_tok(K_PLUS, col, 16'd1);
      CH_MINUS:   add_tok(K_MINUS, col, 16'd1);
      CH_STAR:    add_tok(K_STAR, col, 16'd1);
      CH_SLASH:   add_tok(K_SLASH, col, 16'd1);
      CH_LPAREN:  add_tok(K_LPAREN, col, 16'd1);
      CH_RPAREN:  add_tok(K_RPAREN, col, 16'd1);
      CH_PERCENT: add_tok(K_PERCENT, col, 16'd1);
      CH_LBRACE:  add_tok(K_LBRACE, col, 16'd1);
      CH_RBRACE:  add_tok(K_RBRACE, col, 16'd1);
      CH_DQUOTE:  open_tok(MODE_STR, col, 16'd0);
      CH_SQUOTE:  open_tok(MODE_CHR, col, 16'd0);
      CH_HASH:    open_tok(MODE_COMM, col, 16'd1);
      CH_LT, CH_GT, CH_BANG, CH_AMP, CH_PIPE, CH_EQ: begin
        open_tok(MODE_OP, col, 16'd1);
        op_first = c;
      end
      default: begin
        if (is_num(c)) begin
          open_tok(MODE_NUM, col, 16'd1);
        end else if (is_letter(c)) begin
          open_tok(MODE_IDENT, col, 16'd1);
          word_prefix = {32'h0, c};
        end else begin
          add_tok(K_UNKNOWN, col, 16'd0);
        end
      end
    endcase
  endfunction

  function automatic void lex_byte(input logic [7:0] c, input bit eoi);
    logic [15:0] col;
    bit          taken;
    kind_t       k;
    col    = col_cnt;
    taken  = 1'b0;
    step_n = 0;
    if (c == CH_NL) begin
      close_open();
      if (line_cnt != 16'hFFFF) line_cnt++;
      col_cnt  = '0;
      lex_mode = MODE_START;
    end else begin
      case (lex_mode)
        MODE_SKIP: taken = 1'b1;
        MODE_START: begin
          if (c == CH_HASH) begin
            lex_mode = MODE_SKIP;
            taken    = 1'b1;
          end
        end
        MODE_NUM: begin
          if (is_num(c)) begin
            grow_tok();
            taken = 1'b1;
          end else begin
            add_tok(K_NUMBER, tok_start, tok_len);
          end
        end
        MODE_IDENT: begin
          if (is_letter(c) || is_num(c)) begin
            if (tok_len < 16'd5) word_prefix = {word_prefix[31:0], c};
            grow_tok();
            taken = 1'b1;
          end else begin
            add_tok(word_kind(), tok_start, tok_len);
          end
        end
        MODE_STR, MODE_CHR: begin
          if ((lex_mode == MODE_STR && c == CH_DQUOTE) ||
              (lex_mode == MODE_CHR && c == CH_SQUOTE)) begin
            add_tok((lex_mode == MODE_STR) ? K_STRING : K_CHAR, tok_start, tok_len);
            lex_mode = MODE_IDLE;
          end else begin
            grow_tok();
          end
          taken = 1'b1;
        end
        MODE_COMM: begin
          grow_tok();
          taken = 1'b1;
        end
        MODE_OP: begin
          k = op_pair(op_first, c);
          if (k != K_UNKNOWN) begin
            add_tok(k, tok_start, 16'd2);
            lex_mode = MODE_IDLE;
            taken    = 1'b1;
          end else begin
            k = lone_op(op_first);
            add_tok(k, tok_start, (k == K_UNKNOWN) ? 16'd0 : 16'd1);
          end
        end
        default: ;
      endcase
      if (!taken) take_fresh(c, col);
      if (col_cnt != 16'hFFFF) col_cnt++;
    end
    if (eoi) begin
      close_open();
      lex_reset();
    end
    if (step_n > 0) step_tok[step_n-1].last_of_run = 1'b1;
  endfunction

  // ---------------------------------------------------------------- source
  task automatic send_byte(input logic [7:0] c, input bit eoi, input bit fixed,
                           input logic [1:0] n_fix, input out_beat_t fix_tok);
    if (src_gaps_on && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.char_code    <= c;
    in_ch.end_of_input <= eoi;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    lex_byte(c, eoi);
    if (fixed) begin
      if (n_fix != 2'd0) token_q.insert(token_q.size(), fix_tok);
    end else begin
      for (int i = 0; i < step_n; i++) token_q.insert(token_q.size(), step_tok[i]);
    end
  endtask

  function automatic void add_byte(input logic [7:0] b);
    frag.insert(frag.size(), b);
  endfunction

  function automatic void push_word(input string w);
    for (int i = 0; i < w.len(); i++) add_byte(w[i]);
  endfunction

  function automatic logic [7:0] rand_letter();
    return $urandom_range(0, 1) ? 8'($urandom_range(97, 122)) : 8'($urandom_range(65, 90));
  endfunction

  // printable byte that cannot close the literal or end the line
  function automatic logic [7:0] rand_body(input logic [7:0] closer);
    logic [7:0] b;
    b = 8'($urandom_range(32, 126));
    return (b == closer) ? 8'h61 : b;
  endfunction

  function automatic void gen_fragment();
    int n;
    frag.delete();
    frag_ignored = 1'b0;
    case ($urandom_range(0, 18))
      0, 1, 2: begin
        push_word(kw_words[$urandom_range(0, 11)]);
        if ($urandom_range(0, 3) == 0) add_byte(8'($urandom_range(48, 57)));
      end
      3, 4: begin
        n = $urandom_range(1, 8);
        add_byte(rand_letter());
        for (int i = 1; i < n; i++)
          add_byte($urandom_range(0, 3) == 0 ? 8'($urandom_range(48, 57))
                                             : rand_letter());
      end
      5, 6: begin
        n = $urandom_range(1, 6);
        for (int i = 0; i < n; i++) add_byte(8'($urandom_range(48, 57)));
      end
      7: begin
        add_byte(CH_DQUOTE);
        n = $urandom_range(0, 6);
        for (int i = 0; i < n; i++) add_byte(rand_body(CH_DQUOTE));
        if ($urandom_range(0, 3) != 0) add_byte(CH_DQUOTE);
      end
      8: begin
        add_byte(CH_SQUOTE);
        n = $urandom_range(0, 2);
        for (int i = 0; i < n; i++) add_byte(rand_body(CH_SQUOTE));
        if ($urandom_range(0, 3) != 0) add_byte(CH_SQUOTE);
      end
      9, 10, 11: push_word(op_words[$urandom_range(0, 21)]);
      12: add_byte(CH_NL);
      13: begin
        push_word(" #");
        n = $urandom_range(0, 8);
        for (int i = 0; i < n; i++) add_byte(rand_body(CH_NL));
        add_byte(CH_NL);
      end
      14: begin
        // whole-line comment: the lexer drops body bytes until a newline or end of input
        push_word("\n#");
        n = $urandom_range(0, 8);
        for (int i = 0; i < n; i++) add_byte(8'($urandom_range(0, 255)));
        add_byte(CH_NL);
        frag_ignored = 1'b1;
      end
      15, 16: add_byte(8'($urandom_range(0, 255)));
      default: add_byte(CH_SPACE);
    endcase
    if ($urandom_range(0, 1) == 0) add_byte(CH_SPACE);
  endfunction

  task automatic run_random(input int n_items, input bit with_gaps);
    int done_items;
    done_items = 0;
    while (done_items < n_items) begin
      src_gaps_on = with_gaps && !(done_items >= 200 && done_items < 280);
      snk_gaps_on = with_gaps && !(done_items >= 320 && done_items < 400);
      gen_fragment();
      foreach (frag[i]) send_byte(frag[i], $urandom_range(0, 59) == 0, 1'b0, 2'd0, '0);
      if (!frag_ignored) done_items += frag.size();
    end
  endtask

  // ---------------------------------------------------------------- sink
  always @(posedge clk) begin
    if (snk_hold != 0) begin
      snk_hold--;
      out_ch.ready <= 1'b0;
    end else if (snk_gaps_on && $urandom_range(0, 4) == 0) begin
      snk_hold = $urandom_range(0, 3);
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  function automatic void flag_field(input string what, input logic [15:0] want,
                                     input logic [15:0] got);
    if (want !== got) begin
      $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, what, want, got);
      mismatches++;
    end
  endfunction

  out_beat_t want_tok;

  always @(posedge clk) begin
    if (rst_n && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      if (token_q.size() == 0) begin
        $display("%0t ns: unexpected token beat, expected none, got kind %0d line %0d col %0d",
                 $time, out_ch.token_kind, out_ch.line_number, out_ch.start_column);
        mismatches++;
      end else begin
        want_tok = token_q.pop_front();
        flag_field("token_kind", 16'(want_tok.token_kind), 16'(out_ch.token_kind));
        flag_field("line_number", want_tok.line_number, out_ch.line_number);
        flag_field("start_column", want_tok.start_column, out_ch.start_column);
        flag_field("symbol_length", want_tok.symbol_length, out_ch.symbol_length);
        flag_field("last_of_run", 16'(want_tok.last_of_run), 16'(out_ch.last_of_run));
      end
    end
  end

  // ---------------------------------------------------------------- main
  initial begin : main_seq
    int k;
    rst_n              <= 1'b0;
    in_ch.valid        <= 1'b0;
    in_ch.char_code    <= '0;
    in_ch.end_of_input <= 1'b0;
    lex_reset();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    for (k = 0; k < PROBE_LEN; k++)
      send_byte(PROBE_TEXT[k].ch, PROBE_TEXT[k].eoi, PROBE_TEXT[k].fixed,
                PROBE_TEXT[k].n_res, PROBE_TEXT[k].res);

    run_random(550, 1'b1);

    src_gaps_on = 1'b0;
    snk_gaps_on = 1'b0;
    run_random(150, 1'b0);
    in_ch.valid <= 1'b0;

    while (token_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
